// File: rtl/core/teq_pkg.sv
`timescale 1ns / 1ps

package teq_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int CHAN_W     = 4;
   localparam int ALPHA_W    = 15;
   localparam int GAIN_W     = 16;
   localparam int TRACK_W    = 32;
   localparam int FRAC_OUT   = 30;

   // shared multiplier: 33-bit signed difference by 17-bit signed (zero-extended) factor
   localparam int MUL_A_W    = TRACK_W + 1;
   localparam int MUL_B_W    = GAIN_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = PROD_W + 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET   = 15'd3960;
   localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET  = 15'd17724;
   localparam logic [GAIN_W-1:0]  GAIN_BASS_RESET   = 16'd24576;
   localparam logic [GAIN_W-1:0]  GAIN_MID_RESET    = 16'd19661;
   localparam logic [GAIN_W-1:0]  GAIN_TREBLE_RESET = 16'd6554;

   // half an LSB of the Q0.15 step, for round-half-up
   localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(2**(ALPHA_W-1));
   // added to negative sums so the shift truncates toward zero
   localparam logic signed [ACC_W-1:0]   TRUNC_BIAS = ACC_W'(2**FRAC_OUT - 1);
   // largest Q16.16 value a tracker can take (largest sample)
   localparam logic signed [TRACK_W-1:0] TRACK_MAX  = 32'sh7FFF_0000;

   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      REG_ALPHA_LOW   = 3'd0,
      REG_ALPHA_HIGH  = 3'd1,
      REG_GAIN_BASS   = 3'd2,
      REG_GAIN_MID    = 3'd3,
      REG_GAIN_TREBLE = 3'd4
   } teq_reg_type;

   // datapath step issued by the controller each cycle
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_LOAD,
      OP_STEP_LO,
      OP_STEP_HI,
      OP_SUM_B,
      OP_SUM_M,
      OP_SUM_T,
      OP_FIN
   } teq_op_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha_low;
      logic [ALPHA_W-1:0] alpha_high;
      logic [GAIN_W-1:0]  gain_bass;
      logic [GAIN_W-1:0]  gain_mid;
      logic [GAIN_W-1:0]  gain_treble;
   } teq_cfg_type;

   typedef struct packed {
      logic out_free;
   } teq_status_type;

endpackage

// File: rtl/core/three_band_equalizer_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// req_      in   req_tvalid/req_tready   tdata{sample,channel} tuser=restart tlast=block_end
// rsp_      out  rsp_tvalid/rsp_tready   tdata=sample_out tuser=clipped tlast=block_end_out
// csr_      in   psel/penable/pready     5 regs at byte address 4*i, 32-bit data
//
// One transaction is a capture cycle that reads the channel's tracker
// words, then seven steps around the single 33x17 multiplier (two tracker updates,
// three band weights), ending in the saturate-and-load of the output register.
// The final step holds while the output register is still full and not drained.
// A new request is taken only in idle, so each transaction finishes before the next is taken.
// Reset is synchronous; the per-channel valid bits clear all tracker state, so there
// is no clearing pass and requests are taken right after reset.
// restart marks the channel's trackers as zero for that transaction only.

module three_band_equalizer_core #(
   parameter int CHANNELS = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // [3:0] channel, [19:4] sample, zero pad
   input  logic                              req_tuser,  // [0] restart
   input  logic                              req_tlast,

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // [15:0] sample_out
   output logic                              rsp_tuser,  // [0] clipped
   output logic                              rsp_tlast,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [teq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [teq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [teq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   teq_pkg::teq_cfg_type    cfg;
   teq_pkg::teq_op_type     cmd;
   teq_pkg::teq_status_type sts;

   logic signed [teq_pkg::SAMPLE_W-1:0] out_sample;

   teq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: accepts one transaction and steps the datapath through it
   teq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // tracker memories, shared multiplier, accumulator and output register
   teq_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .sts           (sts),
      .in_channel    (req_tdata[teq_pkg::CHAN_W-1:0]),
      .in_sample     ($signed(req_tdata[teq_pkg::CHAN_W +: teq_pkg::SAMPLE_W])),
      .in_restart    (req_tuser),
      .in_block_end  (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_sample    (out_sample),
      .out_clipped   (rsp_tuser),
      .out_block_end (rsp_tlast)
   );

   assign rsp_tdata = out_sample;

endmodule

// File: rtl/core/teq_csr.sv
`timescale 1ns / 1ps

module teq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [teq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [teq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [teq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output teq_pkg::teq_cfg_type                cfg
);

   teq_pkg::teq_cfg_type cfg_ff, cfg_in;
   teq_pkg::teq_reg_type reg_sel;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = teq_pkg::teq_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            teq_pkg::REG_ALPHA_LOW:   cfg_in.alpha_low   = csr_pwdata[teq_pkg::ALPHA_W-1:0];
            teq_pkg::REG_ALPHA_HIGH:  cfg_in.alpha_high  = csr_pwdata[teq_pkg::ALPHA_W-1:0];
            teq_pkg::REG_GAIN_BASS:   cfg_in.gain_bass   = csr_pwdata[teq_pkg::GAIN_W-1:0];
            teq_pkg::REG_GAIN_MID:    cfg_in.gain_mid    = csr_pwdata[teq_pkg::GAIN_W-1:0];
            teq_pkg::REG_GAIN_TREBLE: cfg_in.gain_treble = csr_pwdata[teq_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         teq_pkg::REG_ALPHA_LOW:
            csr_prdata = teq_pkg::CSR_DATA_W'(cfg_ff.alpha_low);
         teq_pkg::REG_ALPHA_HIGH:
            csr_prdata = teq_pkg::CSR_DATA_W'(cfg_ff.alpha_high);
         teq_pkg::REG_GAIN_BASS:
            csr_prdata = teq_pkg::CSR_DATA_W'(cfg_ff.gain_bass);
         teq_pkg::REG_GAIN_MID:
            csr_prdata = teq_pkg::CSR_DATA_W'(cfg_ff.gain_mid);
         teq_pkg::REG_GAIN_TREBLE:
            csr_prdata = teq_pkg::CSR_DATA_W'(cfg_ff.gain_treble);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_low   <= teq_pkg::ALPHA_LOW_RESET;
         cfg_ff.alpha_high  <= teq_pkg::ALPHA_HIGH_RESET;
         cfg_ff.gain_bass   <= teq_pkg::GAIN_BASS_RESET;
         cfg_ff.gain_mid    <= teq_pkg::GAIN_MID_RESET;
         cfg_ff.gain_treble <= teq_pkg::GAIN_TREBLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/teq_ctrl.sv
`timescale 1ns / 1ps

module teq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  teq_pkg::teq_status_type sts,
   output teq_pkg::teq_op_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STEP_LO,
      ST_STEP_HI,
      ST_SUM_B,
      ST_SUM_M,
      ST_SUM_T,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = teq_pkg::OP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd      = teq_pkg::OP_CAPTURE;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd      = teq_pkg::OP_LOAD;
            state_in = ST_STEP_LO;
         end
         ST_STEP_LO: begin
            cmd      = teq_pkg::OP_STEP_LO;
            state_in = ST_STEP_HI;
         end
         ST_STEP_HI: begin
            cmd      = teq_pkg::OP_STEP_HI;
            state_in = ST_SUM_B;
         end
         ST_SUM_B: begin
            cmd      = teq_pkg::OP_SUM_B;
            state_in = ST_SUM_M;
         end
         ST_SUM_M: begin
            cmd      = teq_pkg::OP_SUM_M;
            state_in = ST_SUM_T;
         end
         ST_SUM_T: begin
            cmd      = teq_pkg::OP_SUM_T;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd      = teq_pkg::OP_FIN;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 (state_ff == ST_FIN))
      else $error("item did not reach the final step in seven cycles");

endmodule

// File: rtl/core/teq_dp.sv
`timescale 1ns / 1ps

module teq_dp #(
   parameter int CHANNELS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  teq_pkg::teq_op_type                   cmd,
   input  teq_pkg::teq_cfg_type                  cfg,
   output teq_pkg::teq_status_type               sts,
   input  logic [teq_pkg::CHAN_W-1:0]            in_channel,
   input  logic signed [teq_pkg::SAMPLE_W-1:0]   in_sample,
   input  logic                                  in_restart,
   input  logic                                  in_block_end,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic signed [teq_pkg::SAMPLE_W-1:0]   out_sample,
   output logic                                  out_clipped,
   output logic                                  out_block_end
);

   localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MAP_SIZE = 2**teq_pkg::CHAN_W;

   localparam int TW = teq_pkg::TRACK_W;
   localparam int AW = teq_pkg::MUL_A_W;
   localparam int BW = teq_pkg::MUL_B_W;
   localparam int PW = teq_pkg::PROD_W;
   localparam int QW = teq_pkg::ACC_W;
   localparam int SW = teq_pkg::SAMPLE_W;

   // channel number folded onto the implemented channels
   logic [CW-1:0] chan_map [MAP_SIZE];
   for (genvar g = 0; g < MAP_SIZE; g++) begin : g_map
      assign chan_map[g] = CW'(g % CHANNELS);
   end

   // tracker memories, one word per channel
   logic [TW-1:0] low_mem  [CHANNELS];
   logic [TW-1:0] high_mem [CHANNELS];
   logic [CHANNELS-1:0] trk_valid_ff, trk_valid_in;

   logic [CW-1:0]          idx_ff, idx_in;
   logic signed [SW-1:0]   sample_ff;
   logic                   bend_ff;
   logic                   hit_ff;
   logic [TW-1:0]          rd_low_ff, rd_high_ff;
   logic signed [TW-1:0]   old_low_ff, old_high_ff, old_low_in, old_high_in;
   logic signed [TW-1:0]   low_new_ff, high_new_ff;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [QW-1:0]   acc_ff, acc_in;

   logic signed [TW-1:0]   x_q;
   logic signed [AW-1:0]   mul_a;
   logic signed [BW-1:0]   mul_b;
   logic signed [PW-1:0]   step_q, trk_sum;
   logic signed [TW-1:0]   trk_base, trk_in;
   logic signed [QW-1:0]   acc_bias;
   logic signed [QW-1:0]   quo;
   logic signed [SW-1:0]   sat_in;
   logic                   clip_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic                   emit;

   assign idx_in = chan_map[in_channel];
   assign x_q    = {sample_ff, {(TW-SW){1'b0}}};

   // restart, or a channel not yet touched since reset, starts from zero
   assign old_low_in  = hit_ff ? $signed(rd_low_ff)  : '0;
   assign old_high_in = hit_ff ? $signed(rd_high_ff) : '0;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd)
         teq_pkg::OP_LOAD: begin
            mul_a = AW'(x_q) - AW'(old_low_in);
            mul_b = BW'(cfg.alpha_low);
         end
         teq_pkg::OP_STEP_LO: begin
            mul_a = AW'(x_q) - AW'(old_high_ff);
            mul_b = BW'(cfg.alpha_high);
         end
         teq_pkg::OP_STEP_HI: begin
            mul_a = AW'(low_new_ff);
            mul_b = BW'(cfg.gain_bass);
         end
         teq_pkg::OP_SUM_B: begin
            mul_a = AW'(high_new_ff) - AW'(low_new_ff);
            mul_b = BW'(cfg.gain_mid);
         end
         teq_pkg::OP_SUM_M: begin
            mul_a = AW'(x_q) - AW'(high_new_ff);
            mul_b = BW'(cfg.gain_treble);
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // tracker step: t + round(d * alpha / 2^15), halves toward plus infinity
   assign step_q   = (prod_ff + teq_pkg::ROUND_HALF) >>> teq_pkg::ALPHA_W;
   assign trk_base = (cmd == teq_pkg::OP_STEP_HI) ? old_high_ff : old_low_ff;
   assign trk_sum  = PW'(trk_base) + step_q;
   assign trk_in   = trk_sum[TW-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (cmd == teq_pkg::OP_SUM_B) begin
         acc_in = QW'(prod_ff);
      end else if (cmd == teq_pkg::OP_SUM_M || cmd == teq_pkg::OP_SUM_T) begin
         acc_in = acc_ff + QW'(prod_ff);
      end
   end

   // Q.30 sum to integer, truncating toward zero, then saturate
   assign acc_bias = acc_ff[QW-1] ? teq_pkg::TRUNC_BIAS : '0;
   assign quo      = (acc_ff + acc_bias) >>> teq_pkg::FRAC_OUT;

   always_comb begin
      priority if (quo > QW'(teq_pkg::OUT_MAX)) begin
         sat_in  = teq_pkg::OUT_MAX;
         clip_in = 1'b1;
      end else if (quo < QW'(teq_pkg::OUT_MIN)) begin
         sat_in  = teq_pkg::OUT_MIN;
         clip_in = 1'b1;
      end else begin
         sat_in  = quo[SW-1:0];
         clip_in = 1'b0;
      end
   end

   assign emit          = (cmd == teq_pkg::OP_FIN);
   assign rsp_tvalid_in = emit ? 1'b1 : (rsp_tvalid_ff && !rsp_tready);

   always_comb begin
      trk_valid_in = trk_valid_ff;
      if (cmd == teq_pkg::OP_SUM_B) begin
         trk_valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_valid_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         trk_valid_ff  <= trk_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == teq_pkg::OP_CAPTURE) begin
         idx_ff     <= idx_in;
         sample_ff  <= in_sample;
         bend_ff    <= in_block_end;
         hit_ff     <= trk_valid_ff[idx_in] && !in_restart;
         rd_low_ff  <= low_mem[idx_in];
         rd_high_ff <= high_mem[idx_in];
      end
      if (cmd == teq_pkg::OP_LOAD) begin
         old_low_ff  <= old_low_in;
         old_high_ff <= old_high_in;
      end
      if (cmd == teq_pkg::OP_STEP_LO) begin
         low_new_ff <= trk_in;
      end
      if (cmd == teq_pkg::OP_STEP_HI) begin
         high_new_ff <= trk_in;
      end
      if (cmd == teq_pkg::OP_SUM_B) begin
         low_mem[idx_ff]  <= low_new_ff;
         high_mem[idx_ff] <= high_new_ff;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (emit) begin
         out_sample    <= sat_in;
         out_clipped   <= clip_in;
         out_block_end <= bend_ff;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      (cmd == teq_pkg::OP_SUM_B) |=> trk_valid_ff[idx_ff])
      else $error("channel not marked valid after tracker write-back");

   a_track_range: assert property (@(posedge clock) disable iff (reset)
      (cmd == teq_pkg::OP_SUM_B) |->
         (low_new_ff <= teq_pkg::TRACK_MAX) && (high_new_ff <= teq_pkg::TRACK_MAX))
      else $error("tracker left the sample range");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_clipped) |->
         (out_sample == teq_pkg::OUT_MAX) || (out_sample == teq_pkg::OUT_MIN))
      else $error("clip flag set on an unsaturated sample");

endmodule
